// ----- hdl/nfup_pkg.sv -----
// ----------------------------------------------------------------------------
// nfup_pkg
// Shared types and constants for the not-frequently-used page replacement
// block: probe record that walks the frame chain, update command, states.
// ----------------------------------------------------------------------------
package nfup_pkg;

    // default build sizes
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 16;

    // fixed field widths
    localparam int CFG_W       = 5;
    localparam int CNT_W       = 32;
    localparam int FRAME_OUT_W = 4;

    // widest values a probe has to carry over the parameter range
    localparam int PAGE_MAX_W = 32;
    localparam int IDX_MAX_W  = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef enum logic {
        UPD_INC,
        UPD_LOAD
    } t_upd_kind;

    // search record handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic                  go;
        logic [PAGE_MAX_W-1:0] page;
        logic                  hit;
        logic [IDX_MAX_W-1:0]  hit_idx;
        logic                  best_set;
        logic [PAGE_MAX_W-1:0] best_page;
        logic [CNT_W-1:0]      best_count;
        logic [CNT_W-1:0]      best_stamp;
        logic [IDX_MAX_W-1:0]  best_idx;
    } t_probe;

    // write-back command broadcast to all cells
    typedef struct packed {
        logic                  we;
        t_upd_kind             kind;
        logic [IDX_MAX_W-1:0]  idx;
        logic [PAGE_MAX_W-1:0] page;
        logic [CNT_W-1:0]      stamp;
    } t_update;

endpackage

// ----- hdl/nfup_cell.sv -----
// ----------------------------------------------------------------------------
// nfup_cell
// One page frame: holds valid, page, use count and load stamp, checks the
// passing probe for a hit and for a better victim, and forwards it.
// ----------------------------------------------------------------------------
module nfup_cell
    import nfup_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int FP_W      = 5
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_probe          i_probe,
    input  logic [FP_W-1:0] i_n_active,
    input  t_update         i_update,
    output t_probe          o_probe
);

    logic                 r_valid;
    logic [PAGE_BITS-1:0] r_page;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_stamp;
    t_probe               r_probe;
    t_probe               n_probe;

    logic w_active;
    logic w_match;
    logic w_better;
    logic w_sel;

    // frame takes part only below the managed frame count
    assign w_active = (FP_W'(INDEX) < i_n_active);
    assign w_match  = w_active && r_valid && (i_probe.page[PAGE_BITS-1:0] == r_page);
    assign w_better = !i_probe.best_set || (r_count < i_probe.best_count) ||
                      ((r_count == i_probe.best_count) && (r_stamp < i_probe.best_stamp));
    assign w_sel    = (i_update.idx == IDX_MAX_W'(INDEX));

    // probe update: first match wins, victim replaced only on strictly better
    always_comb begin
        n_probe = i_probe;
        if (w_match && !i_probe.hit) begin
            n_probe.hit     = 1'b1;
            n_probe.hit_idx = IDX_MAX_W'(INDEX);
        end
        if (w_active && r_valid && w_better) begin
            n_probe.best_set   = 1'b1;
            n_probe.best_page  = PAGE_MAX_W'(r_page);
            n_probe.best_count = r_count;
            n_probe.best_stamp = r_stamp;
            n_probe.best_idx   = IDX_MAX_W'(INDEX);
        end
    end

    // probe register toward the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_update.we && w_sel && (i_update.kind == UPD_LOAD)) begin
            r_valid <= 1'b1;
        end
    end

    // frame contents
    always_ff @(posedge i_clk) begin
        if (i_update.we && w_sel) begin
            case (i_update.kind)
                UPD_LOAD: begin
                    r_page  <= i_update.page[PAGE_BITS-1:0];
                    r_count <= CNT_W'(1);
                    r_stamp <= i_update.stamp;
                end
                UPD_INC: begin
                    if (r_count != '1) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    assign o_probe = r_probe;

endmodule

// ----- hdl/nfu_page_replacement.sv -----
// ----------------------------------------------------------------------------
// nfu_page_replacement
// Not-frequently-used page replacement over a chain of frame cells.
//
//   channel  direction  handshake              payload
//   in       input      i_in_valid/o_in_stall  i_page_number
//   out      output     o_out_valid/i_out_stall o_hit, o_frame_index,
//                                               o_evicted_valid,
//                                               o_evicted_page, o_fault_total
//   cfg      input      i_cfg_valid/o_cfg_ready i_cfg_data (frames_in_use)
//
// Each item runs a probe walk through the frame cells (ST_SCAN), then a
// write-back loading the result (ST_FINISH); ST_IDLE takes the next item.
// One item is in work at a time; o_in_stall is high while it is.
// A result not yet taken holds off write-back of the next one until it is.
// Reset is synchronous, active low, clears valid bits and counters and
// sets the frame count register to 16.
// ----------------------------------------------------------------------------
module nfu_page_replacement
    import nfup_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [PAGE_BITS-1:0]   i_page_number,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_hit,
    output logic [FRAME_OUT_W-1:0] o_frame_index,
    output logic                   o_evicted_valid,
    output logic [PAGE_BITS-1:0]   o_evicted_page,
    output logic [CNT_W-1:0]       o_fault_total,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int FP_W = (FRAMES > 1) ? $clog2(FRAMES + 1) : 1;
    localparam int CW   = (FP_W > CFG_W) ? FP_W : CFG_W;

    t_state r_state;
    t_state n_state;

    logic [CFG_W-1:0] r_cfg;
    logic [FP_W-1:0]  r_fill;
    logic [FP_W-1:0]  n_fill;
    logic [CNT_W-1:0] r_load_seq;
    logic [CNT_W-1:0] n_load_seq;
    logic [CNT_W-1:0] r_fault;
    logic [CNT_W-1:0] n_fault;
    t_probe           r_fin;

    logic                   r_out_valid;
    logic                   r_hit;
    logic [FRAME_OUT_W-1:0] r_frame_index;
    logic                   r_evicted_valid;
    logic [PAGE_BITS-1:0]   r_evicted_page;

    logic                   w_accept;
    logic                   w_finish;
    logic [CW-1:0]          w_cfg_ext;
    logic [FP_W-1:0]        w_n_active;
    t_update                w_update;
    logic [IDX_MAX_W-1:0]   w_target;
    logic                   w_evict;
    logic [PAGE_BITS-1:0]   w_old_page;
    t_probe                 w_head;
    t_probe                 w_chain [FRAMES+1];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && (r_state == ST_IDLE);

    // effective frame count: zero acts as one, clamp to built frames
    always_comb begin
        w_cfg_ext = CW'(r_cfg);
        if (w_cfg_ext == '0) begin
            w_n_active = FP_W'(1);
        end else if (w_cfg_ext > CW'(FRAMES)) begin
            w_n_active = FP_W'(FRAMES);
        end else begin
            w_n_active = FP_W'(w_cfg_ext);
        end
    end

    // probe entering the chain
    always_comb begin
        w_head      = '0;
        w_head.go   = w_accept;
        w_head.page = PAGE_MAX_W'(i_page_number);
    end

    assign w_chain[0] = w_head;

    // frame cells
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        nfup_cell #(
            .INDEX     (g),
            .PAGE_BITS (PAGE_BITS),
            .FP_W      (FP_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_probe    (w_chain[g]),
            .i_n_active (w_n_active),
            .i_update   (w_update),
            .o_probe    (w_chain[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_chain[FRAMES].go) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // write-back decision and result fields
    always_comb begin
        w_finish   = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);
        n_fill     = r_fill;
        n_load_seq = r_load_seq;
        n_fault    = r_fault;
        w_evict    = 1'b0;
        w_old_page = '0;
        w_target   = r_fin.hit_idx;
        w_update       = '0;
        w_update.kind  = UPD_INC;
        w_update.page  = r_fin.page;
        w_update.stamp = r_load_seq;
        if (!r_fin.hit) begin
            w_update.kind = UPD_LOAD;
            if (r_fault != '1) begin
                n_fault = r_fault + CNT_W'(1);
            end
            if (r_load_seq != '1) begin
                n_load_seq = r_load_seq + CNT_W'(1);
            end
            if (r_fill < w_n_active) begin
                w_target = IDX_MAX_W'(r_fill);
                n_fill   = r_fill + FP_W'(1);
            end else begin
                w_target   = r_fin.best_idx;
                w_evict    = r_fin.best_set;
                w_old_page = r_fin.best_page[PAGE_BITS-1:0];
            end
        end
        w_update.we  = w_finish;
        w_update.idx = w_target;
    end

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg   <= CFG_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_load_seq <= '0;
            r_fault    <= '0;
        end else if (w_finish) begin
            r_fill     <= n_fill;
            r_load_seq <= n_load_seq;
            r_fault    <= n_fault;
        end
    end

    // capture probe leaving the chain
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_SCAN) && w_chain[FRAMES].go) begin
            r_fin <= w_chain[FRAMES];
        end
    end

    // output item valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output item payload
    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_hit           <= r_fin.hit;
            r_frame_index   <= FRAME_OUT_W'(w_target);
            r_evicted_valid <= w_evict;
            r_evicted_page  <= w_old_page;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame_index   = r_frame_index;
    assign o_evicted_valid = r_evicted_valid;
    assign o_evicted_page  = r_evicted_page;
    assign o_fault_total   = r_fault;

endmodule
